// ===== rtl/assert_macros.svh =====
// Concurrent assertion helpers; empty when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising i_clk edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every rising i_clk edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== rtl/tfs_pkg.sv =====
`timescale 1ns / 1ps

package tfs_pkg;

    localparam int TEMP_W = 16;
    localparam int ADC_W  = 14;
    localparam int MASK_W = 4;

    localparam int S_TDATA_W = 176;
    localparam int M_TDATA_W = 112;
    localparam int M_TUSER_W = 7;

    // Feedback source codes.
    typedef enum logic [1:0] {
        SRC_BOTH_EXTRA = 2'd0,
        SRC_EXTRA_ONE  = 2'd1,
        SRC_EXTRA_TWO  = 2'd2,
        SRC_PAIR       = 2'd3
    } t_src;

    // Presence mask bit positions.
    localparam int CH_LEFT  = 0;
    localparam int CH_RIGHT = 1;
    localparam int CH_EXT1  = 2;
    localparam int CH_EXT2  = 3;

    typedef struct packed {
        logic        [MASK_W-1:0] present_mask;
        logic signed [TEMP_W-1:0] tc_left;
        logic signed [TEMP_W-1:0] tc_rgt;
        logic signed [TEMP_W-1:0] tc_extra_one;
        logic signed [TEMP_W-1:0] tc_extra_two;
        logic signed [TEMP_W-1:0] cj_left;
        logic signed [TEMP_W-1:0] cj_right;
        logic signed [TEMP_W-1:0] cj_extra_one;
        logic signed [TEMP_W-1:0] cj_extra_two;
        logic        [ADC_W-1:0]  adc_left;
        logic        [ADC_W-1:0]  adc_right;
        logic signed [TEMP_W-1:0] board_temp;
    } t_round;

    typedef struct packed {
        logic signed [TEMP_W-1:0] left_temp;
        logic signed [TEMP_W-1:0] right_temp;
        logic signed [TEMP_W-1:0] extra_one_temp;
        logic signed [TEMP_W-1:0] extra_two_temp;
        logic signed [TEMP_W-1:0] cold_junction;
        logic signed [TEMP_W-1:0] feedback_temp;
        logic signed [TEMP_W-1:0] inner_average;
        t_src                     feedback_source;
        logic        [MASK_W-1:0] valid_mask;
        logic                     cj_present;
    } t_result;

endpackage

// ===== rtl/tfs_calc.sv =====
`timescale 1ns / 1ps

module tfs_calc import tfs_pkg::*; (
    input  t_round                   i_round,
    input  logic                     i_use_ext,
    input  logic signed [TEMP_W-1:0] i_held_one,
    input  logic signed [TEMP_W-1:0] i_held_two,
    output t_result                  o_result
);

    localparam int SUM_W = 19;
    localparam int MAG_W = 17;
    // ceil(2^17 / 3); exact floor for magnitudes below 2^17
    localparam logic [MAG_W-1:0] RECIP3 = 17'd43691;
    localparam logic signed [TEMP_W-1:0] NO_SENSOR_LIMIT = 16'sd2032;  // 127 degC
    localparam logic signed [TEMP_W-1:0] DEFAULT_AMBIENT = 16'sd400;   // 25 degC

    // Signed divide by 2^k, truncating toward zero.
    function automatic logic signed [SUM_W-1:0] f_div_p2(
        input logic signed [SUM_W-1:0] s,
        input logic        [1:0]       k
    );
        logic signed [SUM_W-1:0] bias;
        bias = s[SUM_W-1] ? $signed((19'd1 << k) - 19'd1) : 19'sd0;
        return (s + bias) >>> k;
    endfunction

    // Signed divide by 3, truncating toward zero; |s| stays below 2^17.
    function automatic logic signed [SUM_W-1:0] f_div3(input logic signed [SUM_W-1:0] s);
        logic [MAG_W-1:0]   mag;
        logic [2*MAG_W-1:0] prod;
        logic [MAG_W-1:0]   q;
        mag  = s[SUM_W-1] ? MAG_W'(-s) : MAG_W'(s);
        prod = mag * RECIP3;
        q    = prod[2*MAG_W-1:MAG_W];
        return s[SUM_W-1] ? -$signed({2'b00, q}) : $signed({2'b00, q});
    endfunction

    logic p0, p1, p2, p3;
    logic pair, ext, both;
    logic board_ok;
    logic signed [TEMP_W-1:0] cj_fb;
    logic signed [SUM_W-1:0]  left_fb, right_fb;
    logic signed [SUM_W-1:0]  sum_lr, sum_ext, sum_cj2, sum_cj3, sum_cj4;
    logic signed [SUM_W-1:0]  inner, fb_ext, cj_ext, cj_pair;

    always_comb begin
        p0   = i_round.present_mask[CH_LEFT];
        p1   = i_round.present_mask[CH_RIGHT];
        p2   = i_round.present_mask[CH_EXT1];
        p3   = i_round.present_mask[CH_EXT2];
        pair = p0 && p1;
        ext  = pair && (p2 || p3) && i_use_ext;
        both = p2 && p3;

        // board sensor missing reads as 127 degC or more
        board_ok = i_round.board_temp < NO_SENSOR_LIMIT;
        cj_fb    = board_ok ? i_round.board_temp : DEFAULT_AMBIENT;
        left_fb  = $signed({5'b0, i_round.adc_left})  + SUM_W'(cj_fb);
        right_fb = $signed({5'b0, i_round.adc_right}) + SUM_W'(cj_fb);

        sum_lr  = pair ? SUM_W'(i_round.tc_left) + SUM_W'(i_round.tc_rgt)
                       : left_fb + right_fb;
        sum_ext = SUM_W'(i_round.tc_extra_one) + SUM_W'(i_round.tc_extra_two);
        sum_cj2 = SUM_W'(i_round.cj_left) + SUM_W'(i_round.cj_right);
        sum_cj3 = sum_cj2 + (p2 ? SUM_W'(i_round.cj_extra_one)
                                : SUM_W'(i_round.cj_extra_two));
        sum_cj4 = sum_cj2 + SUM_W'(i_round.cj_extra_one) + SUM_W'(i_round.cj_extra_two);

        inner   = f_div_p2(sum_lr, 2'd1);
        cj_pair = f_div_p2(sum_cj2, 2'd1);
        cj_ext  = both ? f_div_p2(sum_cj4, 2'd2) : f_div3(sum_cj3);
        if (both) begin
            fb_ext = f_div_p2(sum_ext, 2'd1);
        end else if (p2) begin
            fb_ext = SUM_W'(i_round.tc_extra_one);
        end else begin
            fb_ext = SUM_W'(i_round.tc_extra_two);
        end

        o_result.left_temp      = pair ? i_round.tc_left : left_fb[TEMP_W-1:0];
        o_result.right_temp     = pair ? i_round.tc_rgt  : right_fb[TEMP_W-1:0];
        o_result.extra_one_temp = p2 ? i_round.tc_extra_one : i_held_one;
        o_result.extra_two_temp = p3 ? i_round.tc_extra_two : i_held_two;
        o_result.inner_average  = inner[TEMP_W-1:0];
        o_result.feedback_temp  = ext ? fb_ext[TEMP_W-1:0] : inner[TEMP_W-1:0];
        if (ext) begin
            o_result.cold_junction = cj_ext[TEMP_W-1:0];
        end else if (pair) begin
            o_result.cold_junction = cj_pair[TEMP_W-1:0];
        end else begin
            o_result.cold_junction = cj_fb;
        end
        if (!ext) begin
            o_result.feedback_source = SRC_PAIR;
        end else if (both) begin
            o_result.feedback_source = SRC_BOTH_EXTRA;
        end else if (p2) begin
            o_result.feedback_source = SRC_EXTRA_ONE;
        end else begin
            o_result.feedback_source = SRC_EXTRA_TWO;
        end
        o_result.valid_mask = {p3, p2, 2'b11};
        o_result.cj_present = pair || board_ok;
    end

endmodule

// ===== rtl/thermocouple_feedback_select.sv =====
// Thermocouple feedback selector: one conversion round in, one result beat out.
// Path: input register, the single combinational pass, result register.
// Throughput: one beat per cycle unless m_axis_tready stalls the result register.
// Reset (i_rst_n, synchronous, active low) empties both stages, clears the
// external-feedback bit and zeroes the held extra-channel readings.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module thermocouple_feedback_select import tfs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration: use_external_feedback
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    // input round
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata, low bit up: tc_left, tc_rgt, tc_extra_one, tc_extra_two, cj_left,
    // cj_right, cj_extra_one, cj_extra_two, adc_left, adc_right, board_temp, 4 pad bits
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // tuser: present_mask
    input  logic [MASK_W-1:0]    s_axis_tuser,
    // result
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata, low bit up: left_temp, right_temp, extra_one_temp, extra_two_temp,
    // cold_junction, feedback_temp, inner_average
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // tuser, low bit up: feedback_source, valid_mask, cj_present
    output logic [M_TUSER_W-1:0] m_axis_tuser
);

    logic                     r_use_ext;
    logic                     r_in_vld;
    t_round                   r_in;
    logic                     r_out_vld;
    t_result                  r_out;
    logic signed [TEMP_W-1:0] r_held_one;
    logic signed [TEMP_W-1:0] r_held_two;

    t_round  w_round;
    t_result n_out;
    logic    w_adv;
    logic    w_s_beat;

    // Unpack the incoming beat.
    always_comb begin
        w_round.present_mask = s_axis_tuser;
        w_round.tc_left      = s_axis_tdata[15:0];
        w_round.tc_rgt       = s_axis_tdata[31:16];
        w_round.tc_extra_one = s_axis_tdata[47:32];
        w_round.tc_extra_two = s_axis_tdata[63:48];
        w_round.cj_left      = s_axis_tdata[79:64];
        w_round.cj_right     = s_axis_tdata[95:80];
        w_round.cj_extra_one = s_axis_tdata[111:96];
        w_round.cj_extra_two = s_axis_tdata[127:112];
        w_round.adc_left     = s_axis_tdata[141:128];
        w_round.adc_right    = s_axis_tdata[155:142];
        w_round.board_temp   = s_axis_tdata[171:156];
    end

    // Stage 2 moves whenever the result register is empty or being drained;
    // stage 1 takes a new beat whenever it is empty or moving on.
    assign w_adv         = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_adv;
    assign w_s_beat      = s_axis_tvalid && s_axis_tready;

    tfs_calc u_calc (
        .i_round    (r_in),
        .i_use_ext  (r_use_ext),
        .i_held_one (r_held_one),
        .i_held_two (r_held_two),
        .o_result   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_ext  <= 1'b0;
            r_in_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_held_one <= '0;
            r_held_two <= '0;
        end else begin
            if (i_cfg_we) begin
                r_use_ext <= i_cfg_wdata;
            end
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_vld  <= 1'b1;
                // held readings follow the result: absent extras pass the old value
                r_held_one <= n_out.extra_one_temp;
                r_held_two <= n_out.extra_two_temp;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge i_clk) begin
        if (w_s_beat) begin
            r_in <= w_round;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out.inner_average, r_out.feedback_temp, r_out.cold_junction,
                            r_out.extra_two_temp, r_out.extra_one_temp,
                            r_out.right_temp, r_out.left_temp};
    assign m_axis_tuser  = {r_out.cj_present, r_out.valid_mask, r_out.feedback_source};

    // Input stage can only back-pressure while it holds a round.
    `ASSERT_CLK(a_ready_when_empty, !r_in_vld |-> s_axis_tready, "input stall while empty")
    // Held extras change only when a round moves into the result register.
    `ASSERT_CLK(a_held_stable, !w_adv |=> $stable(r_held_one) && $stable(r_held_two),
                "held extra changed without a round")
    // Extra-channel feedback is only chosen with the built-in pair present.
    `ASSERT_CLK(a_ext_has_cj,
                r_out_vld && (r_out.feedback_source != SRC_PAIR) |-> r_out.cj_present,
                "external feedback without cold junction")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import tfs_pkg::*;

    localparam int NO_SENSOR_LIMIT = 2032;  // 127 degC in 1/16 degC
    localparam int AMBIENT_DEFAULT = 400;   // 25 degC in 1/16 degC
    localparam int IDLE_LIMIT      = 2000;  // cycles with no beat on either side
    localparam int PHASE_ROUNDS    = 308;   // random rounds per register setting
    localparam int STEADY_ROUNDS   = 150;   // rounds without idling in one phase

    // Predicts each result from the accepted rounds and checks the output beats.
    class feedback_scoreboard;
        t_result                  expected_rounds[$];
        bit                       ext_feedback_on;
        logic signed [TEMP_W-1:0] held_one;
        logic signed [TEMP_W-1:0] held_two;
        int                       mismatches;

        function new();
            ext_feedback_on = 1'b0;
            held_one        = '0;
            held_two        = '0;
            mismatches      = 0;
        endfunction

        function void set_feedback_mode(bit on);
            ext_feedback_on = on;
        endfunction

        function int pending();
            return expected_rounds.size();
        endfunction

        function t_result predict_round(t_round r);
            t_result res;
            int      left, right, cj, fb;
            int      te1, te2, cl, cr, ce1, ce2, board;
            bit      pl, pr, p1, p2;
            pl    = r.present_mask[CH_LEFT];
            pr    = r.present_mask[CH_RIGHT];
            p1    = r.present_mask[CH_EXT1];
            p2    = r.present_mask[CH_EXT2];
            te1   = $signed(r.tc_extra_one);
            te2   = $signed(r.tc_extra_two);
            cl    = $signed(r.cj_left);
            cr    = $signed(r.cj_right);
            ce1   = $signed(r.cj_extra_one);
            ce2   = $signed(r.cj_extra_two);
            board = $signed(r.board_temp);

            res.valid_mask = 4'b0011;
            res.cj_present = 1'b1;
            // extras are latched in every mode, fallback included
            if (p1) begin
                held_one = r.tc_extra_one;
                res.valid_mask[CH_EXT1] = 1'b1;
            end
            if (p2) begin
                held_two = r.tc_extra_two;
                res.valid_mask[CH_EXT2] = 1'b1;
            end

            if (pl && pr && (p1 || p2) && ext_feedback_on) begin
                if (p1 && p2) begin
                    fb = (te1 + te2) / 2;
                    cj = (cl + cr + ce1 + ce2) / 4;
                    res.feedback_source = SRC_BOTH_EXTRA;
                end else if (p1) begin
                    fb = te1;
                    cj = (cl + cr + ce1) / 3;
                    res.feedback_source = SRC_EXTRA_ONE;
                end else begin
                    fb = te2;
                    cj = (cl + cr + ce2) / 3;
                    res.feedback_source = SRC_EXTRA_TWO;
                end
                left  = $signed(r.tc_left);
                right = $signed(r.tc_rgt);
            end else if (pl && pr) begin
                left  = $signed(r.tc_left);
                right = $signed(r.tc_rgt);
                fb    = (left + right) / 2;
                cj    = (cl + cr) / 2;
                res.feedback_source = SRC_PAIR;
            end else begin
                // a reading at or above 127 degC means no board sensor
                if (board < NO_SENSOR_LIMIT) begin
                    cj = board;
                end else begin
                    cj = AMBIENT_DEFAULT;
                    res.cj_present = 1'b0;
                end
                left  = int'(r.adc_left) + cj;
                right = int'(r.adc_right) + cj;
                fb    = (left + right) / 2;
                res.feedback_source = SRC_PAIR;
            end

            res.left_temp      = 16'(left);
            res.right_temp     = 16'(right);
            res.extra_one_temp = held_one;
            res.extra_two_temp = held_two;
            res.cold_junction  = 16'(cj);
            res.feedback_temp  = 16'(fb);
            res.inner_average  = 16'((left + right) / 2);
            return res;
        endfunction

        function void note_round(t_round r);
            expected_rounds.push_back(predict_round(r));
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0d (%h), expected %0d (%h)",
                    name, $signed(got), got, $signed(want), want));
        endtask

        task check_result(t_result got);
            t_result want;
            if (expected_rounds.size() == 0) begin
                report_mismatch("result beat with no round outstanding");
                return;
            end
            want = expected_rounds.pop_front();
            compare_field("left_temp",       got.left_temp,       want.left_temp);
            compare_field("right_temp",      got.right_temp,      want.right_temp);
            compare_field("extra_one_temp",  got.extra_one_temp,  want.extra_one_temp);
            compare_field("extra_two_temp",  got.extra_two_temp,  want.extra_two_temp);
            compare_field("cold_junction",   got.cold_junction,   want.cold_junction);
            compare_field("feedback_temp",   got.feedback_temp,   want.feedback_temp);
            compare_field("inner_average",   got.inner_average,   want.inner_average);
            compare_field("feedback_source", got.feedback_source, want.feedback_source);
            compare_field("valid_mask",      got.valid_mask,      want.valid_mask);
            compare_field("cj_present",      got.cj_present,      want.cj_present);
        endtask
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic                 i_cfg_wdata   = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [MASK_W-1:0]    s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;

    feedback_scoreboard rounds_sb = new();
    bit                 steady_flow = 1'b0;  // suppresses idling on both sides
    int                 quiet_cycles = 0;

    thermocouple_feedback_select uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Sink side: tready drops about a third of the time unless the flow is steady.
    always @(negedge i_clk)
        m_axis_tready <= steady_flow || ($urandom_range(99) >= 33);

    // Output beats are checked at the rising edge; the watchdog counts edges
    // where neither side moved a beat.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.left_temp       = m_axis_tdata[15:0];
                got.right_temp      = m_axis_tdata[31:16];
                got.extra_one_temp  = m_axis_tdata[47:32];
                got.extra_two_temp  = m_axis_tdata[63:48];
                got.cold_junction   = m_axis_tdata[79:64];
                got.feedback_temp   = m_axis_tdata[95:80];
                got.inner_average   = m_axis_tdata[111:96];
                got.feedback_source = t_src'(m_axis_tuser[1:0]);
                got.valid_mask      = m_axis_tuser[5:2];
                got.cj_present      = m_axis_tuser[6];
                rounds_sb.check_result(got);
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic logic signed [TEMP_W-1:0] rand_temp();
        // mostly full range, some values near zero so the averages straddle it
        if ($urandom_range(99) < 30)
            return 16'(int'($urandom_range(1023)) - 512);
        return 16'($urandom);
    endfunction

    function automatic t_round rand_round();
        t_round r;
        // most rounds have the built-in pair so the extra modes get exercised
        if ($urandom_range(99) < 60)
            r.present_mask = 4'b0011 | 4'($urandom_range(3) << 2);
        else
            r.present_mask = 4'($urandom_range(15));
        r.tc_left      = rand_temp();
        r.tc_rgt       = rand_temp();
        r.tc_extra_one = rand_temp();
        r.tc_extra_two = rand_temp();
        r.cj_left      = rand_temp();
        r.cj_right     = rand_temp();
        r.cj_extra_one = rand_temp();
        r.cj_extra_two = rand_temp();
        r.adc_left     = 14'($urandom);
        r.adc_right    = 14'($urandom);
        if ($urandom_range(99) < 25)
            r.board_temp = 16'($urandom_range(NO_SENSOR_LIMIT + 32, NO_SENSOR_LIMIT - 32));
        else
            r.board_temp = rand_temp();
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat.
    task send_round(input t_round r);
        while (!steady_flow && $urandom_range(99) < 33) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = r.present_mask;
        s_axis_tdata  = {4'b0, r.board_temp, r.adc_right, r.adc_left,
                         r.cj_extra_two, r.cj_extra_one, r.cj_right, r.cj_left,
                         r.tc_extra_two, r.tc_extra_one, r.tc_rgt, r.tc_left};
        do @(posedge i_clk); while (!s_axis_tready);
        rounds_sb.note_round(r);
        @(negedge i_clk);
    endtask

    task drain_results();
        s_axis_tvalid = 1'b0;
        while (rounds_sb.pending() != 0)
            @(negedge i_clk);
    endtask

    // Register writes only with the pipeline empty.
    task write_feedback_mode(input bit on);
        drain_results();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = on;
        @(posedge i_clk);
        rounds_sb.set_feedback_mode(on);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    initial begin
        t_round r;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: every presence mask with external feedback on. The first
        // round shows the held extras at their reset value.
        write_feedback_mode(1'b1);
        for (int m = 0; m < 16; m++) begin
            r = rand_round();
            r.present_mask = 4'(m);
            case (m)
                0: begin
                    r.board_temp = 16'(NO_SENSOR_LIMIT - 1);
                    r.adc_left   = '1;
                    r.adc_right  = '0;
                end
                1: r.board_temp = 16'(NO_SENSOR_LIMIT);
                2: r.board_temp = 16'sh7fff;
                4: begin
                    r.board_temp = 16'sh8000;
                    r.adc_left   = '1;
                    r.adc_right  = '1;
                end
                7: begin
                    r.tc_left  = 16'sh8000;
                    r.tc_rgt   = 16'sh8000;
                    r.cj_left  = 16'sh8000;
                    r.cj_right = 16'sh8000;
                    r.cj_extra_one = 16'sh8000;
                end
                11: begin
                    // negative thirds truncate toward zero
                    r.cj_left      = -16'sd1;
                    r.cj_right     = -16'sd1;
                    r.cj_extra_two = 16'sd0;
                end
                13: r.board_temp = -16'sd5;
                15: begin
                    r.tc_extra_one = 16'sh7fff;
                    r.tc_extra_two = 16'sh7fff;
                    r.cj_left      = 16'sh7fff;
                    r.cj_right     = 16'sh7fff;
                    r.cj_extra_one = 16'sh7fff;
                    r.cj_extra_two = 16'sh7fff;
                end
                default: ;
            endcase
            send_round(r);
        end

        // Directed: with the register clear, extras never drive the feedback.
        write_feedback_mode(1'b0);
        for (int k = 0; k < 4; k++) begin
            r = rand_round();
            r.present_mask = (k == 0) ? 4'b1111 : (k == 1) ? 4'b0011 :
                             (k == 2) ? 4'b1100 : 4'b1011;
            if (k == 1) begin
                r.tc_left  = -16'sd3;
                r.tc_rgt   = 16'sd0;
                r.cj_left  = 16'sh8000;
                r.cj_right = 16'sh8000;
            end
            send_round(r);
        end

        // Random phases, alternating the register; one long steady stretch.
        for (int ph = 0; ph < 4; ph++) begin
            write_feedback_mode(ph[0]);
            for (int n = 0; n < PHASE_ROUNDS; n++) begin
                steady_flow = (ph == 2) && (n < STEADY_ROUNDS);
                send_round(rand_round());
            end
            steady_flow = 1'b0;
        end

        drain_results();
        repeat (8) @(negedge i_clk);
        if (rounds_sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
